/* src/edc_pkg.sv */
// Shared types, stage counts and helpers for the elastic disc collision pipeline.
// No dependencies.
`default_nettype none
package edc_pkg;

   localparam int FrontStages = 4;
   localparam int SqStages    = 32;
   localparam int DivStages   = 31;
   localparam int BackStages  = 9;
   localparam int SatW        = 41;

   typedef struct packed {
      logic signed [31:0] pa_x;
      logic signed [31:0] pa_y;
      logic signed [31:0] va_x;
      logic signed [31:0] va_y;
      logic signed [31:0] pb_x;
      logic signed [31:0] pb_y;
      logic signed [31:0] vb_x;
      logic signed [31:0] vb_y;
   } discs_type;

   typedef struct packed {
      discs_type          d;
      logic               hit;
      logic               act;
      logic               sx;
      logic               sy;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        r;
      logic [31:0]        adx;
      logic [31:0]        ady;
      logic [63:0]        s;
   } front_type;

   typedef struct packed {
      front_type   f;
      logic [34:0] rem;
      logic [31:0] root;
   } sq_type;

   typedef struct packed {
      discs_type          d;
      logic               hit;
      logic               act;
      logic               sx;
      logic               sy;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        ov;
      logic [31:0]        dlen;
      logic [62:0]        num_x;
      logic [62:0]        num_y;
      logic [31:0]        rem_x;
      logic [31:0]        rem_y;
      logic [30:0]        q_x;
      logic [30:0]        q_y;
   } dv_type;

   typedef struct packed {
      discs_type          d;
      logic               hit;
      logic               act;
      logic               sx;
      logic               sy;
      logic               kneg;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        ov;
      logic [30:0]        qx;
      logic [30:0]        qy;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [64:0] kx;
      logic signed [64:0] ky;
      logic [62:0]        cmx;
      logic [62:0]        cmy;
      logic signed [65:0] k;
      logic [32:0]        cmr_x;
      logic [32:0]        cmr_y;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic [64:0]        km;
      logic [35:0]        kqm;
      logic [66:0]        exm;
      logic [66:0]        eym;
      logic [37:0]        exr;
      logic [37:0]        eyr;
      logic signed [38:0] ex;
      logic signed [38:0] ey;
   } bk_type;

   typedef struct packed {
      logic      collided;
      discs_type d;
   } result_type;

   function automatic logic [31:0] sat32(input logic signed [SatW-1:0] v);
      logic [31:0] res;
      if (v[SatW-1:31] == '0 || v[SatW-1:31] == '1) begin
         res = v[31:0];
      end else if (v[SatW-1]) begin
         res = 32'h8000_0000;
      end else begin
         res = 32'h7FFF_FFFF;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* src/edc_req_if.sv */
// Request channel: two discs per transfer.
// No dependencies.
`default_nettype none
interface edc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_a_x;
   logic signed [31:0] pos_a_y;
   logic signed [31:0] vel_a_x;
   logic signed [31:0] vel_a_y;
   logic [30:0]        radius_a;
   logic signed [31:0] pos_b_x;
   logic signed [31:0] pos_b_y;
   logic signed [31:0] vel_b_x;
   logic signed [31:0] vel_b_y;
   logic [30:0]        radius_b;

   modport source (output valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a,
                   pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b, input ready);
   modport sink (input valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a,
                 pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b, output ready);
endinterface
`default_nettype wire

/* src/edc_rsp_if.sv */
// Response channel: collision flag and updated discs per transfer.
// No dependencies.
`default_nettype none
interface edc_rsp_if;
   logic               valid;
   logic               ready;
   logic               collided;
   logic signed [31:0] new_pos_a_x;
   logic signed [31:0] new_pos_a_y;
   logic signed [31:0] new_vel_a_x;
   logic signed [31:0] new_vel_a_y;
   logic signed [31:0] new_pos_b_x;
   logic signed [31:0] new_pos_b_y;
   logic signed [31:0] new_vel_b_x;
   logic signed [31:0] new_vel_b_y;

   modport source (output valid, collided, new_pos_a_x, new_pos_a_y, new_vel_a_x,
                   new_vel_a_y, new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y,
                   input ready);
   modport sink (input valid, collided, new_pos_a_x, new_pos_a_y, new_vel_a_x,
                 new_vel_a_y, new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y,
                 output ready);
endinterface
`default_nettype wire

/* src/elastic_disc_collision.sv */
// Top level of the elastic disc collision pipeline.
// Depends on edc_pkg, edc_req_if, edc_rsp_if, edc_front, edc_sqrt, edc_div, edc_back.
//
//   channel   dir   transfer
//   req_bus   in    two discs: positions, velocities, radii (Q16.16)
//   rsp_bus   out   collided flag and both discs after the collision
//
// One pair per cycle unless a stalled response holds the pipeline; 4 front stages, 32 square
// root (one root bit per stage), 1 + 31 normal division (one quotient bit per stage), 9 back.
// Synchronous reset clears the valid bits only.
// A stalled response freezes all stages; nothing is lost or repeated.
`default_nettype none
module elastic_disc_collision import edc_pkg::*; (
   input logic        clock,
   input logic        reset,
   edc_req_if.sink    req_bus,
   edc_rsp_if.source  rsp_bus
);

   logic       adv;
   discs_type  in_d;
   logic       fr_valid, sq_valid, dv_valid, bk_valid;
   front_type  fr_f;
   sq_type     sq_q;
   dv_type     dv_v;
   result_type res;

   assign adv           = !bk_valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   assign in_d = '{pa_x: req_bus.pos_a_x, pa_y: req_bus.pos_a_y,
                   va_x: req_bus.vel_a_x, va_y: req_bus.vel_a_y,
                   pb_x: req_bus.pos_b_x, pb_y: req_bus.pos_b_y,
                   vb_x: req_bus.vel_b_x, vb_y: req_bus.vel_b_y};

   edc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .in_d      (in_d),
      .in_ra     (req_bus.radius_a),
      .in_rb     (req_bus.radius_b),
      .out_valid (fr_valid),
      .out_f     (fr_f)
   );

   edc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_f      (fr_f),
      .out_valid (sq_valid),
      .out_q     (sq_q)
   );

   edc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_q      (sq_q),
      .out_valid (dv_valid),
      .out_v     (dv_v)
   );

   edc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_v      (dv_v),
      .out_valid (bk_valid),
      .out_r     (res)
   );

   assign rsp_bus.valid       = bk_valid;
   assign rsp_bus.collided    = res.collided;
   assign rsp_bus.new_pos_a_x = res.d.pa_x;
   assign rsp_bus.new_pos_a_y = res.d.pa_y;
   assign rsp_bus.new_vel_a_x = res.d.va_x;
   assign rsp_bus.new_vel_a_y = res.d.va_y;
   assign rsp_bus.new_pos_b_x = res.d.pb_x;
   assign rsp_bus.new_pos_b_y = res.d.pb_y;
   assign rsp_bus.new_vel_b_x = res.d.vb_x;
   assign rsp_bus.new_vel_b_y = res.d.vb_y;

endmodule
`default_nettype wire

/* src/edc_front.sv */
// Front stages: differences, magnitudes, squares and the collision test.
// Depends on edc_pkg.
`default_nettype none
module edc_front import edc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  discs_type   in_d,
   input  logic [30:0] in_ra,
   input  logic [30:0] in_rb,
   output logic        out_valid,
   output front_type   out_f
);

   typedef struct packed {
      discs_type          d;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        r;
   } s1_type;

   typedef struct packed {
      discs_type          d;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        r;
      logic [32:0]        adx;
      logic [32:0]        ady;
      logic               sx;
      logic               sy;
      logic               zero;
   } s2_type;

   typedef struct packed {
      discs_type          d;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        r;
      logic [31:0]        adx;
      logic [31:0]        ady;
      logic               sx;
      logic               sy;
      logic               zero;
      logic [65:0]        dx2;
      logic [65:0]        dy2;
      logic [63:0]        r2;
   } s3_type;

   logic [FrontStages-1:0] vld_ff;
   s1_type    s1_ff, s1_in;
   s2_type    s2_ff, s2_in;
   s3_type    s3_ff, s3_in;
   front_type s4_ff, s4_in;
   logic [65:0] sum;

   always_comb begin
      s1_in.d   = in_d;
      s1_in.dx  = {in_d.pb_x[31], in_d.pb_x} - {in_d.pa_x[31], in_d.pa_x};
      s1_in.dy  = {in_d.pb_y[31], in_d.pb_y} - {in_d.pa_y[31], in_d.pa_y};
      s1_in.dvx = {in_d.vb_x[31], in_d.vb_x} - {in_d.va_x[31], in_d.va_x};
      s1_in.dvy = {in_d.vb_y[31], in_d.vb_y} - {in_d.va_y[31], in_d.va_y};
      s1_in.r   = {1'b0, in_ra} + {1'b0, in_rb};
   end

   always_comb begin
      s2_in.d    = s1_ff.d;
      s2_in.dvx  = s1_ff.dvx;
      s2_in.dvy  = s1_ff.dvy;
      s2_in.r    = s1_ff.r;
      s2_in.sx   = s1_ff.dx[32];
      s2_in.sy   = s1_ff.dy[32];
      s2_in.adx  = s1_ff.dx[32] ? (~s1_ff.dx) + 33'd1 : s1_ff.dx;
      s2_in.ady  = s1_ff.dy[32] ? (~s1_ff.dy) + 33'd1 : s1_ff.dy;
      s2_in.zero = (s1_ff.dx == '0) && (s1_ff.dy == '0);
   end

   always_comb begin
      s3_in.d    = s2_ff.d;
      s3_in.dvx  = s2_ff.dvx;
      s3_in.dvy  = s2_ff.dvy;
      s3_in.r    = s2_ff.r;
      s3_in.adx  = s2_ff.adx[31:0];
      s3_in.ady  = s2_ff.ady[31:0];
      s3_in.sx   = s2_ff.sx;
      s3_in.sy   = s2_ff.sy;
      s3_in.zero = s2_ff.zero;
      s3_in.dx2  = 66'(s2_ff.adx) * 66'(s2_ff.adx);
      s3_in.dy2  = 66'(s2_ff.ady) * 66'(s2_ff.ady);
      s3_in.r2   = 64'(s2_ff.r) * 64'(s2_ff.r);
   end

   always_comb begin
      sum       = s3_ff.dx2 + s3_ff.dy2;
      s4_in.d   = s3_ff.d;
      s4_in.hit = sum < {2'b00, s3_ff.r2};
      s4_in.act = (sum < {2'b00, s3_ff.r2}) && !s3_ff.zero;
      s4_in.sx  = s3_ff.sx;
      s4_in.sy  = s3_ff.sy;
      s4_in.dvx = s3_ff.dvx;
      s4_in.dvy = s3_ff.dvy;
      s4_in.r   = s3_ff.r;
      s4_in.adx = s3_ff.adx;
      s4_in.ady = s3_ff.ady;
      s4_in.s   = sum[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[FrontStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = vld_ff[FrontStages-1];
   assign out_f     = s4_ff;

endmodule
`default_nettype wire

/* src/edc_sqrt.sv */
// Integer square root of the squared center distance, one root bit per stage.
// Depends on edc_pkg.
`default_nettype none
module edc_sqrt import edc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_valid,
   input  front_type in_f,
   output logic      out_valid,
   output sq_type    out_q
);

   logic [SqStages-1:0] vld_ff;
   sq_type st_ff [SqStages];
   sq_type st_in [SqStages];

   for (genvar j = 0; j < SqStages; j++) begin : g_stage
      sq_type      src;
      logic [34:0] tmp;
      logic [34:0] trial;

      if (j == 0) begin : g_first
         assign src = '{f: in_f, rem: '0, root: '0};
      end else begin : g_next
         assign src = st_ff[j-1];
      end

      always_comb begin
         tmp         = {src.rem[32:0], src.f.s[63:62]};
         trial       = {1'b0, src.root, 2'b01};
         st_in[j]    = src;
         st_in[j].f.s = {src.f.s[61:0], 2'b00};
         if (tmp >= trial) begin
            st_in[j].rem  = tmp - trial;
            st_in[j].root = {src.root[30:0], 1'b1};
         end else begin
            st_in[j].rem  = tmp;
            st_in[j].root = {src.root[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[SqStages-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[SqStages-1];
   assign out_q     = st_ff[SqStages-1];

endmodule
`default_nettype wire

/* src/edc_div.sv */
// Unit normal: |dx| * 2^30 / distance rounded, two restoring dividers in lockstep.
// Depends on edc_pkg.
`default_nettype none
module edc_div import edc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   adv,
   input  logic   in_valid,
   input  sq_type in_q,
   output logic   out_valid,
   output dv_type out_v
);

   logic [DivStages:0] vld_ff;
   dv_type pr_ff, pr_in;
   dv_type st_ff [DivStages];
   dv_type st_in [DivStages];

   always_comb begin
      pr_in.d     = in_q.f.d;
      pr_in.hit   = in_q.f.hit;
      pr_in.act   = in_q.f.act;
      pr_in.sx    = in_q.f.sx;
      pr_in.sy    = in_q.f.sy;
      pr_in.dvx   = in_q.f.dvx;
      pr_in.dvy   = in_q.f.dvy;
      pr_in.dlen  = in_q.root;
      pr_in.ov    = in_q.f.r - in_q.root;
      pr_in.num_x = {1'b0, in_q.f.adx, 30'd0} + {32'd0, in_q.root[31:1]};
      pr_in.num_y = {1'b0, in_q.f.ady, 30'd0} + {32'd0, in_q.root[31:1]};
      pr_in.rem_x = pr_in.num_x[62:31];
      pr_in.rem_y = pr_in.num_y[62:31];
      pr_in.q_x   = '0;
      pr_in.q_y   = '0;
   end

   for (genvar j = 0; j < DivStages; j++) begin : g_stage
      localparam int Bit = DivStages - 1 - j;
      dv_type      src;
      logic [32:0] tx;
      logic [32:0] ty;

      if (j == 0) begin : g_first
         assign src = pr_ff;
      end else begin : g_next
         assign src = st_ff[j-1];
      end

      always_comb begin
         tx       = {src.rem_x, src.num_x[Bit]};
         ty       = {src.rem_y, src.num_y[Bit]};
         st_in[j] = src;
         if (tx >= {1'b0, src.dlen}) begin
            st_in[j].rem_x = 32'(tx - {1'b0, src.dlen});
            st_in[j].q_x   = {src.q_x[29:0], 1'b1};
         end else begin
            st_in[j].rem_x = tx[31:0];
            st_in[j].q_x   = {src.q_x[29:0], 1'b0};
         end
         if (ty >= {1'b0, src.dlen}) begin
            st_in[j].rem_y = 32'(ty - {1'b0, src.dlen});
            st_in[j].q_y   = {src.q_y[29:0], 1'b1};
         end else begin
            st_in[j].rem_y = ty[31:0];
            st_in[j].q_y   = {src.q_y[29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff <= pr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DivStages-1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[DivStages];
   assign out_v     = st_ff[DivStages-1];

endmodule
`default_nettype wire

/* src/edc_back.sv */
// Back stages: normal speed, velocity exchange, overlap push and saturation.
// Depends on edc_pkg.
`default_nettype none
module edc_back import edc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  dv_type     in_v,
   output logic       out_valid,
   output result_type out_r
);

   logic [BackStages-1:0] vld_ff;
   bk_type st_ff [BackStages];
   bk_type st_in [BackStages];
   logic [63:0] rnd_x, rnd_y;
   logic [65:0] kneg_val;
   logic [67:0] erx, ery;

   always_comb begin
      // stage 0: signed normal
      st_in[0]      = '0;
      st_in[0].d    = in_v.d;
      st_in[0].hit  = in_v.hit;
      st_in[0].act  = in_v.act;
      st_in[0].sx   = in_v.sx;
      st_in[0].sy   = in_v.sy;
      st_in[0].dvx  = in_v.dvx;
      st_in[0].dvy  = in_v.dvy;
      st_in[0].ov   = in_v.ov;
      st_in[0].qx   = in_v.q_x;
      st_in[0].qy   = in_v.q_y;
      st_in[0].nx   = in_v.sx ? 32'd0 - {1'b0, in_v.q_x} : {1'b0, in_v.q_x};
      st_in[0].ny   = in_v.sy ? 32'd0 - {1'b0, in_v.q_y} : {1'b0, in_v.q_y};

      // stage 1: products
      st_in[1]      = st_ff[0];
      st_in[1].kx   = 65'(st_ff[0].dvx) * 65'(st_ff[0].nx);
      st_in[1].ky   = 65'(st_ff[0].dvy) * 65'(st_ff[0].ny);
      st_in[1].cmx  = 63'(st_ff[0].ov) * 63'(st_ff[0].qx);
      st_in[1].cmy  = 63'(st_ff[0].ov) * 63'(st_ff[0].qy);

      // stage 2: dot product, push rounding
      st_in[2]       = st_ff[1];
      st_in[2].k     = 66'(st_ff[1].kx) + 66'(st_ff[1].ky);
      rnd_x          = {1'b0, st_ff[1].cmx} + 64'h4000_0000;
      rnd_y          = {1'b0, st_ff[1].cmy} + 64'h4000_0000;
      st_in[2].cmr_x = rnd_x[63:31];
      st_in[2].cmr_y = rnd_y[63:31];

      // stage 3: magnitude of k, signed push
      st_in[3]      = st_ff[2];
      kneg_val      = 66'd0 - st_ff[2].k;
      st_in[3].kneg = st_ff[2].k[65];
      st_in[3].km   = st_ff[2].k[65] ? kneg_val[64:0] : st_ff[2].k[64:0];
      st_in[3].cx   = st_ff[2].sx ? 34'd0 - {1'b0, st_ff[2].cmr_x} : {1'b0, st_ff[2].cmr_x};
      st_in[3].cy   = st_ff[2].sy ? 34'd0 - {1'b0, st_ff[2].cmr_y} : {1'b0, st_ff[2].cmr_y};

      // stage 4: k to Q16.16
      st_in[4]     = st_ff[3];
      st_in[4].kqm = {1'b0, st_ff[3].km[64:30]} + {35'd0, st_ff[3].km[29]};

      // stage 5: velocity change products
      st_in[5]     = st_ff[4];
      st_in[5].exm = 67'(st_ff[4].kqm) * 67'(st_ff[4].qx);
      st_in[5].eym = 67'(st_ff[4].kqm) * 67'(st_ff[4].qy);

      // stage 6: round
      st_in[6]     = st_ff[5];
      erx          = {1'b0, st_ff[5].exm} + 68'h2000_0000;
      ery          = {1'b0, st_ff[5].eym} + 68'h2000_0000;
      st_in[6].exr = erx[67:30];
      st_in[6].eyr = ery[67:30];

      // stage 7: sign
      st_in[7]    = st_ff[6];
      st_in[7].ex = (st_ff[6].kneg ^ st_ff[6].sx) ?
                    39'd0 - {1'b0, st_ff[6].exr} : {1'b0, st_ff[6].exr};
      st_in[7].ey = (st_ff[6].kneg ^ st_ff[6].sy) ?
                    39'd0 - {1'b0, st_ff[6].eyr} : {1'b0, st_ff[6].eyr};

      // stage 8: apply and saturate
      st_in[8] = st_ff[7];
      if (st_ff[7].act) begin
         st_in[8].d.va_x = sat32(SatW'(st_ff[7].d.va_x) + SatW'(st_ff[7].ex));
         st_in[8].d.va_y = sat32(SatW'(st_ff[7].d.va_y) + SatW'(st_ff[7].ey));
         st_in[8].d.vb_x = sat32(SatW'(st_ff[7].d.vb_x) - SatW'(st_ff[7].ex));
         st_in[8].d.vb_y = sat32(SatW'(st_ff[7].d.vb_y) - SatW'(st_ff[7].ey));
         st_in[8].d.pa_x = sat32(SatW'(st_ff[7].d.pa_x) - SatW'(st_ff[7].cx));
         st_in[8].d.pa_y = sat32(SatW'(st_ff[7].d.pa_y) - SatW'(st_ff[7].cy));
         st_in[8].d.pb_x = sat32(SatW'(st_ff[7].d.pb_x) + SatW'(st_ff[7].cx));
         st_in[8].d.pb_y = sat32(SatW'(st_ff[7].d.pb_y) + SatW'(st_ff[7].cy));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BackStages-2:0], in_valid};
      end
   end

   assign out_valid      = vld_ff[BackStages-1];
   assign out_r.collided = st_ff[BackStages-1].hit;
   assign out_r.d        = st_ff[BackStages-1].d;

`ifndef ASSERT_OFF
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && st_ff[0].act |-> st_ff[0].qx <= 31'h4000_0000)
      else $error("normal component above one");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("valid bits survive reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for elastic_disc_collision: random and directed disc pairs,
// predicted in-line and compared per field. Depends on edc_pkg, edc_req_if, edc_rsp_if.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import edc_pkg::*;

   localparam int RandomPairs = 1300;
   localparam int CycleLimit  = 400000;
   localparam int DrainWait   = 200;
   localparam int HoldAt      = 300;
   localparam int HoldCycles  = 400;
   localparam int PauseAt     = 850;
   localparam longint unsigned MagCap = 64'd1 << 62;

   typedef struct packed {
      logic signed [31:0] pa_x;
      logic signed [31:0] pa_y;
      logic signed [31:0] va_x;
      logic signed [31:0] va_y;
      logic [30:0]        ra;
      logic signed [31:0] pb_x;
      logic signed [31:0] pb_y;
      logic signed [31:0] vb_x;
      logic signed [31:0] vb_y;
      logic [30:0]        rb;
   } pair_type;

   localparam int PairW = $bits(pair_type);

   logic clock;
   logic reset;
   edc_req_if req_bus();
   edc_rsp_if rsp_bus();

   elastic_disc_collision DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   pair_type   pair_q[$];
   result_type expected_q[$];
   pair_type   offered;
   bit         offering;
   int         sent;
   int         errors;
   int         hold_left;
   bit         hold_done;
   longint     cycles;

   function automatic longint round_shift(longint v, int sh);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m >> sh) + ((m >> (sh - 1)) & 1);
      if (m > MagCap) m = MagCap;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint mul_round(longint a, longint b, int sh);
      logic [127:0] pr;
      longint unsigned ma, mb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      pr = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (sh - 1))) >> sh;
      if (pr > MagCap) pr = MagCap;
      return ((a < 0) != (b < 0)) ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   function automatic logic [31:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic result_type collide(pair_type p);
      result_type res;
      longint pax, pay, vax, vay, pbx, pby, vbx, vby, dx, dy, nx, ny;
      longint k, kq, ex, ey, cx, cy;
      longint unsigned adx, ady, r, dlen, c;
      logic [127:0] s, rr;
      pax = p.pa_x; pay = p.pa_y; vax = p.va_x; vay = p.va_y;
      pbx = p.pb_x; pby = p.pb_y; vbx = p.vb_x; vby = p.vb_y;
      dx = pbx - pax;
      dy = pby - pay;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      r = longint'(p.ra) + longint'(p.rb);
      s = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
      rr = {64'd0, r} * {64'd0, r};
      res.collided = s < rr;
      if (res.collided && s != 0) begin
         dlen = 0;
         for (int b = 33; b >= 0; b--) begin
            c = dlen | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s) dlen = c;
         end
         nx = ((adx << 30) + dlen / 2) / dlen;
         ny = ((ady << 30) + dlen / 2) / dlen;
         if (dx < 0) nx = -nx;
         if (dy < 0) ny = -ny;
         k = (vbx - vax) * nx + (vby - vay) * ny;
         kq = round_shift(k, 30);
         ex = mul_round(kq, nx, 30);
         ey = mul_round(kq, ny, 30);
         cx = mul_round(longint'(r - dlen), nx, 31);
         cy = mul_round(longint'(r - dlen), ny, 31);
         vax += ex; vay += ey; vbx -= ex; vby -= ey;
         pax -= cx; pay -= cy; pbx += cx; pby += cy;
      end
      res.d.pa_x = clip32(pax); res.d.pa_y = clip32(pay);
      res.d.va_x = clip32(vax); res.d.va_y = clip32(vay);
      res.d.pb_x = clip32(pbx); res.d.pb_y = clip32(pby);
      res.d.vb_x = clip32(vbx); res.d.vb_y = clip32(vby);
      return res;
   endfunction

   function automatic pair_type make_pair(int pax, int pay, int vax, int vay, int ra,
                                          int pbx, int pby, int vbx, int vby, int rb);
      pair_type p;
      p.pa_x = pax; p.pa_y = pay; p.va_x = vax; p.va_y = vay; p.ra = ra[30:0];
      p.pb_x = pbx; p.pb_y = pby; p.vb_x = vbx; p.vb_y = vby; p.rb = rb[30:0];
      return p;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int sh;
      p = PairW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 9) < 8) begin
         sh = $urandom_range(0, 26);
         p.pb_x = p.pa_x + ($signed($urandom) >>> sh);
         p.pb_y = p.pa_y + ($signed($urandom) >>> sh);
         p.ra = 31'($urandom >> (sh + 1));
         p.rb = 31'($urandom >> (sh + 1));
         if ($urandom_range(0, 1)) begin
            p.va_x = $signed(p.va_x) >>> $urandom_range(0, 20);
            p.va_y = $signed(p.va_y) >>> $urandom_range(0, 20);
            p.vb_x = $signed(p.vb_x) >>> $urandom_range(0, 20);
            p.vb_y = $signed(p.vb_y) >>> $urandom_range(0, 20);
         end
         if ($urandom_range(0, 49) == 0) begin
            p.pb_x = p.pa_x;
            p.pb_y = p.pa_y;
         end
      end
      return p;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // input transfer bookkeeping and response checking
   always @(posedge clock) begin
      result_type e;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_q.push_back(collide(offered));
         sent++;
         offering = 0;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response transfer");
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("collided", {31'd0, e.collided}, {31'd0, rsp_bus.collided});
            check_field("new_pos_a_x", e.d.pa_x, rsp_bus.new_pos_a_x);
            check_field("new_pos_a_y", e.d.pa_y, rsp_bus.new_pos_a_y);
            check_field("new_vel_a_x", e.d.va_x, rsp_bus.new_vel_a_x);
            check_field("new_vel_a_y", e.d.va_y, rsp_bus.new_vel_a_y);
            check_field("new_pos_b_x", e.d.pb_x, rsp_bus.new_pos_b_x);
            check_field("new_pos_b_y", e.d.pb_y, rsp_bus.new_pos_b_y);
            check_field("new_vel_b_x", e.d.vb_x, rsp_bus.new_vel_b_x);
            check_field("new_vel_b_y", e.d.vb_y, rsp_bus.new_vel_b_y);
         end
      end
   end

   // driver
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (sent < 450) ? 25 : (sent < 900) ? 66 : 0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!offering) begin
         if (pair_q.size() != 0 && !(sent == PauseAt && expected_q.size() != 0)
             && $urandom_range(0, 99) >= idle_pct) begin
            offered = pair_q.pop_front();
            offering = 1;
            req_bus.valid <= 1'b1;
            req_bus.pos_a_x <= offered.pa_x;
            req_bus.pos_a_y <= offered.pa_y;
            req_bus.vel_a_x <= offered.va_x;
            req_bus.vel_a_y <= offered.va_y;
            req_bus.radius_a <= offered.ra;
            req_bus.pos_b_x <= offered.pb_x;
            req_bus.pos_b_y <= offered.pb_y;
            req_bus.vel_b_x <= offered.vb_x;
            req_bus.vel_b_y <= offered.vb_y;
            req_bus.radius_b <= offered.rb;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (sent < 450) ? 66 : (sent < 900) ? 25 : 0;
      if (!hold_done && sent >= HoldAt) begin
         hold_done = 1;
         hold_left = HoldCycles;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   initial begin
      req_bus.valid = 0;
      req_bus.pos_a_x = 0; req_bus.pos_a_y = 0; req_bus.vel_a_x = 0; req_bus.vel_a_y = 0;
      req_bus.radius_a = 0; req_bus.pos_b_x = 0; req_bus.pos_b_y = 0;
      req_bus.vel_b_x = 0; req_bus.vel_b_y = 0; req_bus.radius_b = 0;
      rsp_bus.ready = 0;
      reset = 1;
      // both radii zero, coincident centers: no collision
      pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // coincident centers with radius: flagged, unchanged
      pair_q.push_back(make_pair(5 << 16, 7 << 16, 1 << 16, 2 << 16, 1 << 16,
                                 5 << 16, 7 << 16, -3 << 16, 4 << 16, 0));
      // head-on along x, overlapping
      pair_q.push_back(make_pair(0, 0, 1 << 16, 0, 1 << 16,
                                 3 << 15, 0, -(1 << 16), 0, 1 << 16));
      // along y, overlapping
      pair_q.push_back(make_pair(0, 0, 0, 2 << 16, 1 << 16,
                                 0, -(1 << 16), 0, -(5 << 16), 1 << 16));
      // exactly touching: no collision
      pair_q.push_back(make_pair(0, 0, 1, 1, 1 << 16, 2 << 16, 0, 3, 3, 1 << 16));
      // far apart
      pair_q.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h7FFF_FFFF, 0));
      // maximum radii over the full span, diagonal
      pair_q.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF));
      // position saturation on push
      pair_q.push_back(make_pair(32'h7FFF_FFF0, 0, 0, 0, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));
      pair_q.push_back(make_pair(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF,
                                 32'h8000_0010, 0, 0, 0, 32'h7FFF_FFFF));
      // velocity saturation on exchange
      pair_q.push_back(make_pair(0, 0, 32'h8000_0000, 0, 1 << 16,
                                 1 << 15, 0, 32'h7FFF_FFFF, 0, 1 << 16));
      pair_q.push_back(make_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1 << 16,
                                 -(1 << 14), -(1 << 14), 32'h8000_0000, 32'h8000_0000,
                                 1 << 16));
      // minimal separation, one LSB
      pair_q.push_back(make_pair(0, 0, 5, -5, 1, 1, 1, -5, 5, 1));
      pair_q.push_back(make_pair(-1, 0, 100, 0, 0, 0, 0, -100, 0, 2));
      for (int i = 0; i < RandomPairs; i++) pair_q.push_back(random_pair());
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (pair_q.size() == 0 && !offering);
      wait (expected_q.size() == 0);
      repeat (DrainWait) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
